// ----- hw/rtl/bimodal_insertion_replacement_top_defines.svh -----
// Assertion macros shared by the checker of the bimodal insertion replacement block.
`ifndef BIMODAL_INSERTION_REPLACEMENT_TOP_DEFINES_SVH
`define BIMODAL_INSERTION_REPLACEMENT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that is also checked around reset.
`define BIR_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bir_pkg.sv -----
// Package with the constants and types of the bimodal insertion replacement block.
`default_nettype none

package bir_pkg;

  localparam int SETS     = 64;
  localparam int WAYS     = 16;
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W    = $clog2(WAYS);
  localparam int WAYS_P2  = 1 << WAY_W;

  localparam int SET_IDX_W    = 6;
  localparam int HIT_WAY_W    = 4;
  localparam int DRAW_W       = 7;
  localparam int STAMP_W      = 64;
  localparam int PCT_W        = 7;
  localparam int VICTIM_WAY_W = 4;

  localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(50);

  localparam int FIFO_DEPTH = 2;

  // What the back end has to do with one word.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_STAMP,
    OP_MISS
  } bir_op_t;

  typedef struct packed {
    bir_op_t             op;
    logic [SET_W-1:0]    set;
    logic [WAY_W-1:0]    way;
    logic                ins_mru;
    logic [STAMP_W-1:0]  stamp;
  } bir_cmd_t;

  typedef struct packed {
    logic clearing;
  } bir_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bir_in_if.sv -----
// Access channel interface: valid, ready and the access fields.
`default_nettype none

interface bir_in_if;
  import bir_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SET_IDX_W-1:0]  set_index;
  logic                  is_hit;
  logic [HIT_WAY_W-1:0]  hit_way;
  logic                  is_write;
  logic [DRAW_W-1:0]     random_draw;
  logic [STAMP_W-1:0]    cycle_now;

  modport source (
    output valid, set_index, is_hit, hit_way, is_write, random_draw, cycle_now,
    input  ready
  );

  modport sink (
    input  valid, set_index, is_hit, hit_way, is_write, random_draw, cycle_now,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/bir_out_if.sv -----
// Result channel interface: valid, ready and the victim fields.
`default_nettype none

interface bir_out_if;
  import bir_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     victim_valid;
  logic [VICTIM_WAY_W-1:0]  victim_way;

  modport source (
    output valid, victim_valid, victim_way,
    input  ready
  );

  modport sink (
    input  valid, victim_valid, victim_way,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/bir_front.sv -----
// Front end: takes access words, classifies them and holds the insert percentage.
`default_nettype none

module bir_front (
  input  logic                     clk,
  input  logic                     rst_n,
  bir_in_if.sink                   in_ch,
  input  logic                     cfg_wr_en,
  input  logic [bir_pkg::PCT_W-1:0] cfg_wr_data,
  input  bir_pkg::bir_status_t     status,
  output logic                     push_valid,
  output bir_pkg::bir_cmd_t        push_cmd,
  input  logic                     push_ready
);
  import bir_pkg::*;

  logic [PCT_W-1:0] insert_pct_r;
  logic             slot_valid_r;
  bir_cmd_t         slot_r;
  bir_cmd_t         cmd_nxt;
  logic             accept;

  assign in_ch.ready = !status.clearing && (!slot_valid_r || push_ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // A read hit on an existing way stamps it; a write hit or a hit on a way
  // past the end changes nothing; every miss goes through victim selection.
  always_comb begin
    cmd_nxt.op = OP_MISS;
    if (in_ch.is_hit) begin
      if (!in_ch.is_write && (int'(in_ch.hit_way) < WAYS)) begin
        cmd_nxt.op = OP_STAMP;
      end else begin
        cmd_nxt.op = OP_NONE;
      end
    end
    cmd_nxt.set     = SET_W'(in_ch.set_index % SETS);
    cmd_nxt.way     = WAY_W'(in_ch.hit_way);
    cmd_nxt.ins_mru = in_ch.random_draw < insert_pct_r;
    cmd_nxt.stamp   = in_ch.cycle_now;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r <= cmd_nxt;
    end
    if (!rst_n) begin
      insert_pct_r <= PCT_RESET;
      slot_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        insert_pct_r <= cfg_wr_data;
      end
      if (accept) begin
        slot_valid_r <= 1'b1;
      end else if (push_ready) begin
        slot_valid_r <= 1'b0;
      end
    end
  end

  assign push_valid = slot_valid_r;
  assign push_cmd   = slot_r;

endmodule

`default_nettype wire

// ----- hw/rtl/bir_fifo.sv -----
// Short command queue between the front end and the back end.
`default_nettype none

module bir_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  bir_pkg::bir_cmd_t  push_cmd,
  output logic               push_ready,
  output logic               pop_valid,
  output bir_pkg::bir_cmd_t  pop_cmd,
  input  logic               pop_ready
);
  import bir_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  bir_cmd_t          entry_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count_r != CNT_W'(FIFO_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bir_back.sv -----
// Back end: stamp memory, clearing pass, victim search tree and result register.
`default_nettype none

module bir_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  input  bir_pkg::bir_cmd_t                 pop_cmd,
  output logic                              pop_ready,
  output bir_pkg::bir_status_t              status,
  output logic                              out_valid,
  output logic                              out_victim_valid,
  output logic [bir_pkg::VICTIM_WAY_W-1:0]  out_victim_way,
  input  logic                              out_ready
);
  import bir_pkg::*;

  localparam int HALF  = WAYS_P2 / 2;
  localparam int LVL_W = $clog2(WAY_W + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_REDUCE,
    S_FILL
  } state_t;

  state_t                   state_r, state_nxt;
  logic [SET_W-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic [LVL_W-1:0]         lvl_r, lvl_nxt;
  bir_cmd_t                 cur_r, cur_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_vv_r, out_vv_nxt;
  logic [VICTIM_WAY_W-1:0]  out_way_r, out_way_nxt;
  logic                     out_free;

  logic [WAYS-1:0]          wr_en;
  logic [SET_W-1:0]         wr_addr;
  logic [STAMP_W-1:0]       wr_data;
  logic [SET_W-1:0]         rd_addr;

  logic [STAMP_W-1:0]       lvl0_stamp [WAYS_P2];
  logic [WAY_W-1:0]         lvl0_way   [WAYS_P2];
  logic [STAMP_W-1:0]       src_stamp  [WAYS_P2];
  logic [WAY_W-1:0]         src_way    [WAYS_P2];
  logic [STAMP_W-1:0]       red_stamp  [HALF];
  logic [WAY_W-1:0]         red_way    [HALF];
  logic [STAMP_W-1:0]       cand_stamp_r [HALF];
  logic [WAY_W-1:0]         cand_way_r   [HALF];

  assign rd_addr = pop_cmd.set;

  // One bank per way, all read at the same set; padding ways beyond the
  // real count read as the largest stamp so they never win.
  for (genvar j = 0; j < WAYS_P2; j++) begin : g_way
    if (j < WAYS) begin : g_bank
      logic [STAMP_W-1:0] bank_mem [SETS];
      logic [STAMP_W-1:0] rd_data_r;

      always_ff @(posedge clk) begin
        if (wr_en[j]) begin
          bank_mem[wr_addr] <= wr_data;
        end
        rd_data_r <= bank_mem[rd_addr];
      end

      assign lvl0_stamp[j] = rd_data_r;
    end else begin : g_pad
      assign lvl0_stamp[j] = '1;
    end
    assign lvl0_way[j] = WAY_W'(j);
  end

  // One level of the minimum tree; the left side wins ties.
  always_comb begin
    for (int i = 0; i < WAYS_P2; i++) begin
      if (state_r == S_LOAD) begin
        src_stamp[i] = lvl0_stamp[i];
        src_way[i]   = lvl0_way[i];
      end else if (i < HALF) begin
        src_stamp[i] = cand_stamp_r[i];
        src_way[i]   = cand_way_r[i];
      end else begin
        src_stamp[i] = '1;
        src_way[i]   = '1;
      end
    end
    for (int i = 0; i < HALF; i++) begin
      if (src_stamp[2*i+1] < src_stamp[2*i]) begin
        red_stamp[i] = src_stamp[2*i+1];
        red_way[i]   = src_way[2*i+1];
      end else begin
        red_stamp[i] = src_stamp[2*i];
        red_way[i]   = src_way[2*i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD || state_r == S_REDUCE) begin
      for (int i = 0; i < HALF; i++) begin
        cand_stamp_r[i] <= red_stamp[i];
        cand_way_r[i]   <= red_way[i];
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    lvl_nxt       = lvl_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_vv_nxt    = out_vv_r;
    out_way_nxt   = out_way_r;
    pop_ready     = 1'b0;
    wr_en         = '0;
    wr_addr       = pop_cmd.set;
    wr_data       = pop_cmd.stamp;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = '1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
        if (clr_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (pop_valid) begin
          if (pop_cmd.op == OP_MISS) begin
            pop_ready = 1'b1;
            cur_nxt   = pop_cmd;
            state_nxt = S_LOAD;
          end else if (out_free) begin
            pop_ready = 1'b1;
            if (pop_cmd.op == OP_STAMP) begin
              wr_en[pop_cmd.way] = 1'b1;
            end
            out_valid_nxt = 1'b1;
            out_vv_nxt    = 1'b0;
            out_way_nxt   = '0;
          end
        end
      end
      S_LOAD: begin
        lvl_nxt   = LVL_W'(1);
        state_nxt = (WAY_W == 1) ? S_FILL : S_REDUCE;
      end
      S_REDUCE: begin
        lvl_nxt = lvl_r + 1'b1;
        if (lvl_nxt == LVL_W'(WAY_W)) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        wr_addr = cur_r.set;
        wr_data = cur_r.ins_mru ? cur_r.stamp : '0;
        if (out_free) begin
          wr_en[cand_way_r[0]] = 1'b1;
          out_valid_nxt        = 1'b1;
          out_vv_nxt           = 1'b1;
          out_way_nxt          = VICTIM_WAY_W'(cand_way_r[0]);
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    out_vv_r  <= out_vv_nxt;
    out_way_r <= out_way_nxt;
    lvl_r     <= lvl_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.clearing  = state_r == S_CLEAR;
  assign out_valid        = out_valid_r;
  assign out_victim_valid = out_vv_r;
  assign out_victim_way   = out_way_r;

endmodule

`default_nettype wire

// ----- hw/rtl/bimodal_insertion_replacement_top.sv -----
// Top level of the bimodal insertion replacement block.
//
//   Channel | Direction | Handshake        | Contents
//   --------+-----------+------------------+------------------------------------------
//   in_ch   | in        | valid / ready    | set_index, is_hit, hit_way, is_write,
//           |           |                  | random_draw, cycle_now
//   out_ch  | out       | valid / ready    | victim_valid, victim_way
//   cfg_*   | in        | cfg_wr_en only   | cfg_wr_data = insert_percent
//
// A hit word, read or write, is handled in S_IDLE of the back end, so hits stream at
// one word per cycle while out_ch is not stalled. A miss passes through the registered
// read of the set row, WAY_W levels of the minimum tree and the fill; the back end
// takes no new word until the fill. After reset it clears the stamp memory one set
// per cycle, SETS sets (64 here), with in_ch.ready low; configuration writes are taken.
// The result register and the command queue let either side stall on its own.
`default_nettype none

module bimodal_insertion_replacement_top (
  input  logic                      clk,
  input  logic                      rst_n,
  bir_in_if.sink                    in_ch,
  bir_out_if.source                 out_ch,
  input  logic                      cfg_wr_en,
  input  logic [bir_pkg::PCT_W-1:0] cfg_wr_data
);
  import bir_pkg::*;

  // Front to queue.
  logic         push_valid;
  bir_cmd_t     push_cmd;
  logic         push_ready;

  // Queue to back.
  logic         pop_valid;
  bir_cmd_t     pop_cmd;
  logic         pop_ready;

  // The back end tells the front end when the clearing pass is still running, so
  // that no word is taken before every stamp reads as zero.
  bir_status_t  status;

  bir_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .status      (status),
    .push_valid  (push_valid),
    .push_cmd    (push_cmd),
    .push_ready  (push_ready)
  );

  // Two entries let the front end go on taking words while a miss walks through
  // the search tree, until the queue is full.
  bir_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  // The back end owns the stamp memory, so all reads and writes to it stay in
  // word order and a miss always sees the stamps left by the word before it.
  bir_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_cmd          (pop_cmd),
    .pop_ready        (pop_ready),
    .status           (status),
    .out_valid        (out_ch.valid),
    .out_victim_valid (out_ch.victim_valid),
    .out_victim_way   (out_ch.victim_way),
    .out_ready        (out_ch.ready)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/bir_checker.sv -----
// Port-level checker for the bimodal insertion replacement block and its bind.
`default_nettype none

`include "bimodal_insertion_replacement_top_defines.svh"

module bir_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_victim_valid,
  input  logic [3:0]  out_victim_way
);

  // Words taken in whose results have not yet left.
  logic [3:0] pending_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  `BIR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_victim_valid) && $stable(out_victim_way), "result changed while stalled")

  `BIR_ASSERT_NOW(a_way_zero, clk, rst_n, out_valid && !out_victim_valid, out_victim_way == 4'd0, "victim way not zero without a victim")

  `BIR_ASSERT_NOW(a_no_extra, clk, rst_n, out_valid, pending_r != 4'd0, "result without a pending word")

  `BIR_ASSERT_ALWAYS(a_clear_pass, clk, rst_n && $past(!rst_n), !in_ready, "word taken during the clearing pass")

endmodule

bind bimodal_insertion_replacement_top bir_checker u_bir_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_victim_valid (out_ch.victim_valid),
  .out_victim_way   (out_ch.victim_way)
);

`default_nettype wire
